/* hw/rtl/pdfl_pkg.sv */
package pdfl_pkg;

    // Table resolution of the log2 and exp2 interpolation tables.
    localparam int LOG_TABLE_BITS = 10;
    localparam int TAB_SIZE       = (1 << LOG_TABLE_BITS) + 1;
    localparam int LOG_REM_W      = 32 - LOG_TABLE_BITS;
    localparam int EXP_REM_W      = 24 - LOG_TABLE_BITS;
    localparam int LOG_IN_W       = 34;
    localparam int LOG_OUT_W      = 30;
    localparam int LOG_EXP_W      = 6;

    typedef enum logic [2:0] {
        CFG_LINEAR_ENABLE  = 3'd0,
        CFG_GAIN           = 3'd1,
        CFG_EXPOSURE_SCALE = 3'd2,
        CFG_LIN_A          = 3'd3,
        CFG_LIN_B          = 3'd4,
        CFG_INV_NORM_POWER = 3'd5,
        CFG_LIN_EXPONENT   = 3'd6
    } t_cfg_idx;

    localparam logic [2:0] SPC_NORMAL    = 3'd0;
    localparam logic [2:0] SPC_NULL      = 3'd1;
    localparam logic [2:0] SPC_HIGH_REPR = 3'd5;

    typedef logic [24:0] t_log_tab [TAB_SIZE];
    typedef logic [31:0] t_exp_tab [TAB_SIZE];

    // Fractional log2 of (1 + i/2^B) in Q.24, one result bit per squaring.
    function automatic t_log_tab f_log_tab();
        t_log_tab    tab;
        logic [63:0] m;
        logic [24:0] r;
        for (int i = 0; i < (1 << LOG_TABLE_BITS); i++) begin
            m = (64'(1 << LOG_TABLE_BITS) + 64'(i)) << (31 - LOG_TABLE_BITS);
            r = '0;
            for (int t = 0; t < 24; t++) begin
                m = (m * m) >> 31;
                r = {r[23:0], 1'b0};
                if (m >= 64'h0000_0001_0000_0000) begin
                    r[0] = 1'b1;
                    m    = m >> 1;
                end
            end
            tab[i] = r;
        end
        tab[1 << LOG_TABLE_BITS] = 25'h100_0000;
        return tab;
    endfunction

    function automatic logic [63:0] f_isqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(i/2^B) in Q1.30, built from repeated square roots of two.
    function automatic t_exp_tab f_exp_tab();
        t_exp_tab    tab;
        logic [63:0] c [LOG_TABLE_BITS];
        logic [63:0] acc;
        c[0] = f_isqrt(64'h2000_0000_0000_0000);
        for (int p = 1; p < LOG_TABLE_BITS; p++) begin
            c[p] = f_isqrt(c[p-1] << 30);
        end
        for (int i = 0; i < (1 << LOG_TABLE_BITS); i++) begin
            acc = 64'h4000_0000;
            for (int q = LOG_TABLE_BITS - 1; q >= 0; q--) begin
                if (((i >> q) & 1) != 0) begin
                    acc = (acc * c[LOG_TABLE_BITS-1-q]) >> 30;
                end
            end
            tab[i] = acc[31:0];
        end
        tab[1 << LOG_TABLE_BITS] = 32'h8000_0000;
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = f_log_tab();
    localparam t_exp_tab EXP_TAB = f_exp_tab();

endpackage

/* hw/rtl/pdfl_in_if.sv */
interface pdfl_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        raw_value;
    logic [2:0]         raw_special;
    logic signed [23:0] dark_value;
    logic               dark_special;
    logic [23:0]        flat_value;
    logic               flat_special;

    modport source (
        output valid, raw_value, raw_special, dark_value, dark_special,
               flat_value, flat_special,
        input  ready
    );
    modport sink (
        input  valid, raw_value, raw_special, dark_value, dark_special,
               flat_value, flat_special,
        output ready
    );
endinterface

/* hw/rtl/pdfl_out_if.sv */
interface pdfl_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] cal_value;
    logic [2:0]         cal_special;

    modport source (output valid, cal_value, cal_special, input ready);
    modport sink (input valid, cal_value, cal_special, output ready);
endinterface

/* hw/rtl/pdfl_log2.sv */
// Five-stage log2 in Q.24: leading one, normalize, table read, slope
// product, final sum. Advances only when i_en is high.
module pdfl_log2 (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [pdfl_pkg::LOG_IN_W-1:0]      i_v,
    output logic [pdfl_pkg::LOG_OUT_W-1:0]     o_log
);

    logic [pdfl_pkg::LOG_EXP_W-1:0]                 w_e;
    logic [pdfl_pkg::LOG_IN_W-1:0]                  w_x;
    logic [31:0]                                    w_frac;
    logic [pdfl_pkg::LOG_TABLE_BITS:0]              w_idx_hi;

    logic [pdfl_pkg::LOG_IN_W-1:0]                  r1_v;
    logic [pdfl_pkg::LOG_EXP_W-1:0]                 r1_e;
    logic [pdfl_pkg::LOG_TABLE_BITS-1:0]            r2_idx;
    logic [pdfl_pkg::LOG_REM_W-1:0]                 r2_rem;
    logic [pdfl_pkg::LOG_EXP_W-1:0]                 r2_e;
    logic [24:0]                                    r3_lo;
    logic [24:0]                                    r3_hi;
    logic [pdfl_pkg::LOG_REM_W-1:0]                 r3_rem;
    logic [pdfl_pkg::LOG_EXP_W-1:0]                 r3_e;
    logic [25+pdfl_pkg::LOG_REM_W-1:0]              r4_prod;
    logic [24:0]                                    r4_lo;
    logic [pdfl_pkg::LOG_EXP_W-1:0]                 r4_e;
    logic [pdfl_pkg::LOG_OUT_W-1:0]                 r5_log;

    always_comb begin
        w_e = '0;
        for (int k = 0; k < pdfl_pkg::LOG_IN_W; k++) begin
            if (i_v[k]) begin
                w_e = pdfl_pkg::LOG_EXP_W'(k);
            end
        end
    end

    assign w_x      = r1_v << (pdfl_pkg::LOG_EXP_W'(pdfl_pkg::LOG_IN_W - 1) - r1_e);
    assign w_frac   = w_x[pdfl_pkg::LOG_IN_W-2 -: 32];
    assign w_idx_hi = {1'b0, r2_idx} + (pdfl_pkg::LOG_TABLE_BITS+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v    <= i_v;
            r1_e    <= w_e;
            r2_idx  <= w_frac[31 -: pdfl_pkg::LOG_TABLE_BITS];
            r2_rem  <= w_frac[pdfl_pkg::LOG_REM_W-1:0];
            r2_e    <= r1_e;
            r3_lo   <= pdfl_pkg::LOG_TAB[{1'b0, r2_idx}];
            r3_hi   <= pdfl_pkg::LOG_TAB[w_idx_hi];
            r3_rem  <= r2_rem;
            r3_e    <= r2_e;
            r4_prod <= (25+pdfl_pkg::LOG_REM_W)'(r3_hi - r3_lo)
                     * (25+pdfl_pkg::LOG_REM_W)'(r3_rem);
            r4_lo   <= r3_lo;
            r4_e    <= r3_e;
            r5_log  <= {r4_e, 24'b0} + pdfl_pkg::LOG_OUT_W'(r4_lo)
                     + pdfl_pkg::LOG_OUT_W'(r4_prod >> pdfl_pkg::LOG_REM_W);
        end
    end

    assign o_log = r5_log;

endmodule

/* hw/rtl/pdfl_exp2.sv */
// Three-stage exp2 of a fraction in Q1.30: table read, slope product, sum.
module pdfl_exp2 (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [pdfl_pkg::LOG_TABLE_BITS-1:0] i_idx,
    input  logic [pdfl_pkg::EXP_REM_W-1:0]      i_rem,
    output logic [31:0]                         o_m
);

    logic [pdfl_pkg::LOG_TABLE_BITS:0]     w_idx_hi;
    logic [31:0]                           r1_lo;
    logic [31:0]                           r1_hi;
    logic [pdfl_pkg::EXP_REM_W-1:0]        r1_rem;
    logic [32+pdfl_pkg::EXP_REM_W-1:0]     r2_prod;
    logic [31:0]                           r2_lo;
    logic [31:0]                           r3_m;

    assign w_idx_hi = {1'b0, i_idx} + (pdfl_pkg::LOG_TABLE_BITS+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lo   <= pdfl_pkg::EXP_TAB[{1'b0, i_idx}];
            r1_hi   <= pdfl_pkg::EXP_TAB[w_idx_hi];
            r1_rem  <= i_rem;
            r2_prod <= (32+pdfl_pkg::EXP_REM_W)'(r1_hi - r1_lo)
                     * (32+pdfl_pkg::EXP_REM_W)'(r1_rem);
            r2_lo   <= r1_lo;
            r3_m    <= r2_lo + 32'(r2_prod >> pdfl_pkg::EXP_REM_W);
        end
    end

    assign o_m = r3_m;

endmodule

/* hw/rtl/pixel_dark_flat_linearity_calibrator.sv */
// Channel   Dir  Handshake      Payload
// i_pix     in   valid / ready  raw_value, raw_special, dark/flat value+special
// o_pix     out  valid / ready  cal_value (signed Q31.8), cal_special
// i_cfg_*   in   write enable   i_cfg_idx selects register, i_cfg_data holds it
//
// One pixel enters per cycle, except while a stalled output holds the pipeline.
// The pipeline depth is set by the log2 unit, the exp2 unit and the split 56x62 bit
// output multiplication, each cut into register stages.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. A stalled output freezes all stages at once, so a
// transaction is neither lost nor repeated.
module pixel_dark_flat_linearity_calibrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdfl_in_if.sink     i_pix,
    pdfl_out_if.source  o_pix,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NSTG    = 20;
    localparam int SIDE_N  = 14;
    localparam int LIN_N   = 13;
    localparam int N_DLY   = 3;
    localparam int TAIL_N  = 4;
    localparam logic [63:0] DCAP     = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [82:0] OUT_POS  = 83'h7F_FFFF_FFFF;
    localparam logic [82:0] OUT_NEG  = 83'h80_0000_0000;

    // Per-pixel values that ride alongside the linearity path.
    typedef struct packed {
        logic signed [33:0] d;
        logic [2:0]         code;
        logic [23:0]        flat;
        logic               zero;
    } t_side;

    typedef struct packed {
        logic [2:0] code;
        logic       neg;
    } t_tail;

    // Configuration registers.
    logic               r_lin_en;
    logic [23:0]        r_gain;
    logic [31:0]        r_exp_scale;
    logic signed [23:0] r_lin_a;
    logic signed [23:0] r_lin_b;
    logic [31:0]        r_inv_norm;
    logic [15:0]        r_lin_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_en    <= 1'b0;
            r_gain      <= 24'd65536;
            r_exp_scale <= 32'd65536;
            r_lin_a     <= 24'sd1048576;
            r_lin_b     <= '0;
            r_inv_norm  <= 32'd65536;
            r_lin_exp   <= 16'd4096;
        end else if (i_cfg_we) begin
            case (pdfl_pkg::t_cfg_idx'(i_cfg_idx))
                pdfl_pkg::CFG_LINEAR_ENABLE:  r_lin_en    <= i_cfg_data[0];
                pdfl_pkg::CFG_GAIN:           r_gain      <= i_cfg_data[23:0];
                pdfl_pkg::CFG_EXPOSURE_SCALE: r_exp_scale <= i_cfg_data;
                pdfl_pkg::CFG_LIN_A:          r_lin_a     <= i_cfg_data[23:0];
                pdfl_pkg::CFG_LIN_B:          r_lin_b     <= i_cfg_data[23:0];
                pdfl_pkg::CFG_INV_NORM_POWER: r_inv_norm  <= i_cfg_data;
                pdfl_pkg::CFG_LIN_EXPONENT:   r_lin_exp   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // All stages share one enable; it drops only while the output register
    // holds a transaction the sink has not taken.
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en        = !r_vld[NSTG-1] || o_pix.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // Stage 1: dark-corrected value d = round((raw*gain + dark*256) / 256)
    // and the special code. A negative d with linearity on becomes Null.
    logic [39:0]        w_raw_gain;
    logic signed [41:0] w_dsum;
    logic signed [33:0] w_d;
    t_side              w_side;

    assign w_raw_gain = 40'(i_pix.raw_value) * 40'(r_gain);
    assign w_dsum     = $signed({2'b00, w_raw_gain})
                      + (42'(i_pix.dark_value) <<< 8) + 42'sd128;
    assign w_d        = 34'(w_dsum >>> 8);

    always_comb begin
        w_side.d    = w_d;
        w_side.flat = i_pix.flat_value;
        w_side.zero = (w_d == '0) || (r_inv_norm == '0);
        if (i_pix.raw_special != pdfl_pkg::SPC_NORMAL) begin
            if (i_pix.raw_special <= pdfl_pkg::SPC_HIGH_REPR) begin
                w_side.code = i_pix.raw_special;
            end else begin
                w_side.code = pdfl_pkg::SPC_NULL;
            end
        end else if (i_pix.dark_special || i_pix.flat_special) begin
            w_side.code = pdfl_pkg::SPC_NULL;
        end else if (r_lin_en && w_d < 0) begin
            w_side.code = pdfl_pkg::SPC_NULL;
        end else begin
            w_side.code = pdfl_pkg::SPC_NORMAL;
        end
    end

    t_side r_side [SIDE_N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int i = 1; i < SIDE_N; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Linear term round(lin_a*d / 2^20), formed in stage 2 and carried along.
    logic signed [57:0] w_lin_p;
    logic signed [37:0] r_lin_q [LIN_N];

    assign w_lin_p = 58'(r_lin_a) * 58'(r_side[0].d);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin_q[0] <= 38'((w_lin_p + 58'sd524288) >>> 20);
            for (int i = 1; i < LIN_N; i++) begin
                r_lin_q[i] <= r_lin_q[i-1];
            end
        end
    end

    // Stages 2 to 6: log2 of d and of the normalizing reciprocal.
    logic [pdfl_pkg::LOG_OUT_W-1:0] w_log_d;
    logic [pdfl_pkg::LOG_OUT_W-1:0] w_log_inv;

    pdfl_log2 u_log_d (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (pdfl_pkg::LOG_IN_W'(r_side[0].d)),
        .o_log (w_log_d)
    );

    pdfl_log2 u_log_inv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (pdfl_pkg::LOG_IN_W'(r_inv_norm)),
        .o_log (w_log_inv)
    );

    // Stage 7: base log. Stage 8: times the exponent. Stage 9: rounded
    // exponent split into integer part n and table index and remainder.
    logic signed [31:0]                  r7_lb;
    logic signed [47:0]                  r8_yp;
    logic signed [35:0]                  w_y;
    logic signed [11:0]                  r9_n;
    logic [pdfl_pkg::LOG_TABLE_BITS-1:0] r9_idx;
    logic [pdfl_pkg::EXP_REM_W-1:0]      r9_rem;
    logic signed [11:0]                  r_n_q [N_DLY];

    assign w_y = 36'((r8_yp + 48'sd2048) >>> 12);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_lb  <= $signed({2'b00, w_log_d}) + $signed({2'b00, w_log_inv})
                    - 32'sd671088640;
            r8_yp  <= 48'($signed({1'b0, r_lin_exp})) * 48'(r7_lb);
            r9_n   <= 12'(w_y >>> 24);
            r9_idx <= w_y[23 -: pdfl_pkg::LOG_TABLE_BITS];
            r9_rem <= w_y[pdfl_pkg::EXP_REM_W-1:0];
            r_n_q[0] <= r9_n;
            for (int i = 1; i < N_DLY; i++) begin
                r_n_q[i] <= r_n_q[i-1];
            end
        end
    end

    // Stages 10 to 12: mantissa of 2^f.
    logic [31:0] w_m;

    pdfl_exp2 u_exp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_idx (r9_idx),
        .i_rem (r9_rem),
        .o_m   (w_m)
    );

    // Stage 13: magnitude |lin_b| * M. Stage 14: scaled by 2^(n-30) with
    // rounding half up on right shifts and a clamp on left shifts.
    logic [23:0]        w_b_abs;
    logic [55:0]        r13_mag;
    logic signed [11:0] r13_n;
    logic signed [12:0] w_sh;
    logic [12:0]        w_k;
    logic [63:0]        w_shl;
    logic [56:0]        w_shr;
    logic [61:0]        w_pw;
    logic [61:0]        r14_pw;

    assign w_b_abs = r_lin_b[23] ? 24'(-r_lin_b) : 24'(r_lin_b);
    assign w_sh    = 13'(r13_n) - 13'sd30;
    assign w_k     = 13'(-w_sh);
    assign w_shl   = 64'(r13_mag) << w_sh[3:0];
    assign w_shr   = 57'(r13_mag) >> (w_k[5:0] - 6'd1);

    always_comb begin
        if (r13_mag == '0) begin
            w_pw = '0;
        end else if (!w_sh[12]) begin
            if (w_sh >= 13'sd9 || w_shl > DCAP) begin
                w_pw = DCAP[61:0];
            end else begin
                w_pw = w_shl[61:0];
            end
        end else if (w_k >= 13'd57) begin
            w_pw = '0;
        end else begin
            w_pw = 62'((w_shr + 57'd1) >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r13_mag <= 56'(w_b_abs) * 56'(w_m);
            r13_n   <= r_n_q[N_DLY-1];
            r14_pw  <= w_pw;
        end
    end

    // Stage 15: corrected d, clamped, or the plain d; and exposure * flat.
    logic signed [63:0] w_pw_s;
    logic signed [63:0] w_corr;
    logic signed [62:0] w_dsel;
    logic signed [62:0] r15_dsel;
    logic [55:0]        r15_xf;
    logic [2:0]         r15_code;

    assign w_pw_s = r_side[SIDE_N-1].zero ? 64'sd0
                  : (r_lin_b[23] ? -$signed({2'b00, r14_pw}) : $signed({2'b00, r14_pw}));
    assign w_corr = 64'(r_lin_q[LIN_N-1]) + w_pw_s;

    always_comb begin
        if (!r_lin_en) begin
            w_dsel = 63'(r_side[SIDE_N-1].d);
        end else if (w_corr > $signed(DCAP)) begin
            w_dsel = 63'($signed(DCAP));
        end else if (w_corr < -$signed(DCAP)) begin
            w_dsel = 63'(-$signed(DCAP));
        end else begin
            w_dsel = 63'(w_corr);
        end
    end

    // Stages 16 to 20: magnitude, four partial products, an adder tree, then
    // rounding half away from zero at 2^36 and saturation to 40 bits.
    logic [61:0]  r16_dm;
    logic [55:0]  r16_xf;
    logic [59:0]  r17_p00;
    logic [57:0]  r17_p01;
    logic [59:0]  r17_p10;
    logic [57:0]  r17_p11;
    logic [90:0]  r18_t0;
    logic [90:0]  r18_t1;
    logic [118:0] r19_tot;
    t_tail        r_tail [TAIL_N];
    logic [82:0]  w_q;
    logic [82:0]  w_limit;
    logic [39:0]  w_qmag;
    logic [39:0]  w_val;
    logic [39:0]  r_out_value;
    logic [2:0]   r_out_code;

    assign w_q     = 83'((120'(r19_tot) + 120'h8_0000_0000) >> 36);
    assign w_limit = r_tail[TAIL_N-1].neg ? OUT_NEG : OUT_POS;
    assign w_qmag  = (w_q > w_limit) ? w_limit[39:0] : w_q[39:0];
    assign w_val   = (r_tail[TAIL_N-1].code != pdfl_pkg::SPC_NORMAL) ? 40'd0
                   : (r_tail[TAIL_N-1].neg ? 40'(-w_qmag) : w_qmag);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r15_dsel <= w_dsel;
            r15_xf   <= 56'(r_exp_scale) * 56'(r_side[SIDE_N-1].flat);
            r15_code <= r_side[SIDE_N-1].code;

            r16_dm        <= r15_dsel[62] ? 62'(-r15_dsel) : 62'(r15_dsel);
            r16_xf        <= r15_xf;
            r_tail[0]     <= '{code: r15_code, neg: r15_dsel[62]};
            for (int i = 1; i < TAIL_N; i++) begin
                r_tail[i] <= r_tail[i-1];
            end

            r17_p00 <= 60'(r16_xf[27:0])  * 60'(r16_dm[31:0]);
            r17_p01 <= 58'(r16_xf[27:0])  * 58'(r16_dm[61:32]);
            r17_p10 <= 60'(r16_xf[55:28]) * 60'(r16_dm[31:0]);
            r17_p11 <= 58'(r16_xf[55:28]) * 58'(r16_dm[61:32]);

            r18_t0 <= 91'(r17_p00) + (91'(r17_p01) << 32);
            r18_t1 <= 91'(r17_p10) + (91'(r17_p11) << 32);

            r19_tot <= 119'(r18_t0) + (119'(r18_t1) << 28);

            r_out_value <= w_val;
            r_out_code  <= r_tail[TAIL_N-1].code;
        end
    end

    assign o_pix.valid       = r_vld[NSTG-1];
    assign o_pix.cal_value   = r_out_value;
    assign o_pix.cal_special = r_out_code;

    // A special result always carries a zero value.
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.cal_special != pdfl_pkg::SPC_NORMAL
        |-> o_pix.cal_value == '0)
        else $error("special result with nonzero value");

    // Only defined special codes leave the block.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> o_pix.cal_special <= pdfl_pkg::SPC_HIGH_REPR)
        else $error("undefined special code on output");

    // An accepted transaction occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    // A stall freezes every valid bit.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule
